[hdl/ttv_pkg.sv]
// ----------------------------------------------------------------------------
// ttv_pkg
// Shared types, codes, constants and small tables of the text field parser.
// ----------------------------------------------------------------------------
package ttv_pkg;

  typedef enum logic [2:0] {
    VT_INT16     = 3'd0,
    VT_INT32     = 3'd1,
    VT_INT64     = 3'd2,
    VT_BOOL      = 3'd3,
    VT_DATE      = 3'd4,
    VT_TIMESTAMP = 3'd5,
    VT_STRING    = 3'd6,
    VT_INT128    = 3'd7
  } value_type_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY_INT   = 3'd1,
    ST_BAD_INT     = 3'd2,
    ST_NOT_BOOL    = 3'd3,
    ST_BAD_DATE    = 3'd4,
    ST_UNSUPPORTED = 3'd5
  } status_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_MINUS = 8'h2D;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_TAB   = 8'h09;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [4:0]  POS_MAX    = 5'd31;
  localparam logic [4:0]  DATE_LEN   = 5'd10;
  localparam logic [4:0]  TS_LEN     = 5'd19;
  localparam logic [63:0] INT64_MAG_DIV10 = 64'd922337203685477580;
  localparam logic [63:0] INT64_NEG_MAG   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT16_MAX = 64'h0000_0000_0000_7FFF;
  localparam logic [63:0] INT32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  // Year is offset by 400 so that the Gregorian correction stays positive.
  localparam logic [14:0] YEAR_BIAS    = 15'd400;
  localparam logic [31:0] EPOCH_OFFSET = 32'd865565;
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;

  // One entry of the queue between the front and the back.
  typedef struct packed {
    value_type_t ftype;
    logic        has_char;
    logic [7:0]  ch;
    logic [4:0]  pos;
    logic        rep_bad;
    logic        last;
    logic [4:0]  len;
    logic        seen;
  } op_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_sep(input logic [4:0] p);
    return (p == 5'd4) || (p == 5'd7) || (p == 5'd10) || (p == 5'd13) || (p == 5'd16);
  endfunction

  function automatic logic [7:0] true_char(input logic [4:0] p);
    logic [7:0] c;
    case (p)
      5'd0: c = 8'h74;
      5'd1: c = 8'h72;
      5'd2: c = 8'h75;
      5'd3: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] false_char(input logic [4:0] p);
    logic [7:0] c;
    case (p)
      5'd0: c = 8'h66;
      5'd1: c = 8'h61;
      5'd2: c = 8'h6C;
      5'd3: c = 8'h73;
      5'd4: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Day of the year at which each month starts, counting from March.
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:  d = 9'd0;
      4'd1:  d = 9'd31;
      4'd2:  d = 9'd61;
      4'd3:  d = 9'd92;
      4'd4:  d = 9'd122;
      4'd5:  d = 9'd153;
      4'd6:  d = 9'd184;
      4'd7:  d = 9'd214;
      4'd8:  d = 9'd245;
      4'd9:  d = 9'd275;
      4'd10: d = 9'd306;
      4'd11: d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[hdl/ttv_char_if.sv]
// ----------------------------------------------------------------------------
// ttv_char_if
// Character channel: one byte of a text field per transfer.
// ----------------------------------------------------------------------------
interface ttv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       last;
  logic [2:0] value_type;

  modport source (output valid, char_code, char_valid, last, value_type, input ready);
  modport sink (input valid, char_code, char_valid, last, value_type, output ready);
endinterface

[hdl/ttv_result_if.sv]
// ----------------------------------------------------------------------------
// ttv_result_if
// Result channel: one typed value and status per transfer.
// ----------------------------------------------------------------------------
interface ttv_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [2:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

[hdl/ttv_front.sv]
// ----------------------------------------------------------------------------
// ttv_front
// Strips whitespace, tracks the text position and emits one queue entry per
// fed character or field end.
// ----------------------------------------------------------------------------
module ttv_front
  import ttv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ttv_char_if.sink  field_in,
  input  logic      q_full,
  output logic      push,
  output op_t       push_op
);

  logic        in_field;
  value_type_t ftype;
  logic        seen;
  logic [4:0]  tpos;
  logic [4:0]  pend;

  logic        in_field_next;
  value_type_t ftype_next;
  logic        seen_next;
  logic [4:0]  tpos_next;
  logic [4:0]  pend_next;

  logic        accept;
  value_type_t ft;
  logic        seen_cur;
  logic [4:0]  tpos_cur;
  logic [4:0]  pend_cur;
  logic [5:0]  replay_end;
  logic [4:0]  np;
  logic [5:0]  p_plus1;
  logic [4:0]  lim;
  logic        has_char;
  logic        rep_bad;

  assign field_in.ready = !q_full;
  assign accept = field_in.valid && field_in.ready;

  always_comb begin
    ft       = in_field ? ftype : value_type_t'(field_in.value_type);
    seen_cur = in_field ? seen : 1'b0;
    tpos_cur = in_field ? tpos : 5'd0;
    pend_cur = in_field ? pend : 5'd0;
    has_char = field_in.char_valid && !is_space(field_in.char_code);

    // Pending whitespace is replayed ahead of the next non-space byte.
    replay_end = {1'b0, tpos_cur} + {1'b0, pend_cur};
    np         = (replay_end > {1'b0, POS_MAX}) ? POS_MAX : replay_end[4:0];
    p_plus1    = {1'b0, tpos_cur} + 6'd1;
    lim        = (ft == VT_DATE) ? DATE_LEN : TS_LEN;

    rep_bad = 1'b0;
    if (pend_cur != 5'd0) begin
      case (ft)
        VT_INT16, VT_INT32, VT_INT64, VT_BOOL: rep_bad = 1'b1;
        VT_DATE, VT_TIMESTAMP: begin
          rep_bad = (tpos_cur < lim && !is_sep(tpos_cur)) ||
                    (pend_cur >= 5'd2 && p_plus1 < {1'b0, lim});
        end
        default: rep_bad = 1'b0;
      endcase
    end

    seen_next  = seen_cur;
    tpos_next  = tpos_cur;
    pend_next  = pend_cur;
    if (field_in.char_valid) begin
      if (has_char) begin
        seen_next = 1'b1;
        pend_next = 5'd0;
        tpos_next = (np == POS_MAX) ? POS_MAX : np + 5'd1;
      end else if (seen_cur && pend_cur != POS_MAX) begin
        pend_next = pend_cur + 5'd1;
      end
    end
    in_field_next = !field_in.last;
    ftype_next    = ft;

    push             = accept && (has_char || field_in.last);
    push_op.ftype    = ft;
    push_op.has_char = has_char;
    push_op.ch       = field_in.char_code;
    push_op.pos      = np;
    push_op.rep_bad  = rep_bad;
    push_op.last     = field_in.last;
    push_op.len      = tpos_next;
    push_op.seen     = seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_field <= 1'b0;
      ftype    <= VT_INT16;
      seen     <= 1'b0;
      tpos     <= 5'd0;
      pend     <= 5'd0;
    end else if (accept) begin
      in_field <= in_field_next;
      ftype    <= ftype_next;
      seen     <= seen_next;
      tpos     <= tpos_next;
      pend     <= pend_next;
    end
  end

  a_field_closes: assert property (@(posedge clk) disable iff (rst)
    accept && field_in.last |=> !in_field)
    else $error("field still open after its final transfer");

endmodule

[hdl/ttv_queue.sv]
// ----------------------------------------------------------------------------
// ttv_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module ttv_queue
  import ttv_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  op_t           slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full      = (count == FULL_COUNT);
  assign pop_valid = (count != '0);
  assign pop_op    = slots[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      case ({push && !full, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue written while full");

endmodule

[hdl/ttv_back.sv]
// ----------------------------------------------------------------------------
// ttv_back
// Accumulates the fed characters of a field and, at its end, works out the
// typed value through a short pipeline into the output register.
// ----------------------------------------------------------------------------
module ttv_back
  import ttv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  op_t          q_op,
  output logic         q_pop,
  ttv_result_if.source result_out
);

  typedef struct packed {
    value_type_t ftype;
    logic [4:0]  len;
    logic        seen;
    logic        neg;
    logic [63:0] mag;
    logic        dseen;
    logic        malf;
    logic [1:0]  bm;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } acc_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] val;
    logic        date_go;
    logic        is_ts;
    logic [14:0] yp;
    logic [8:0]  doyb;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } s2_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] val;
    logic        date_go;
    logic        is_ts;
    logic [23:0] y365;
    logic [12:0] y4;
    logic [7:0]  q100;
    logic [5:0]  q400;
    logic [8:0]  doyb;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } s3_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] val;
    logic        date_go;
    logic        is_ts;
    logic [31:0] days;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } s4_t;

  typedef struct packed {
    status_t            status;
    logic [63:0]        val;
    logic               date_go;
    logic               is_ts;
    logic [31:0]        days;
    logic signed [49:0] day_secs;
    logic [18:0]        hms;
  } s5_t;

  localparam acc_t ACC_CLEAR = '{ftype: VT_INT16, len: 5'd0, seen: 1'b0, neg: 1'b0,
                                 mag: 64'd0, dseen: 1'b0, malf: 1'b0, bm: 2'b11,
                                 year: 14'd0, month: 7'd0, day: 7'd0, hour: 7'd0,
                                 minute: 7'd0, second: 7'd0};

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] d);
    return 7'({a, 3'b000} + {a, 1'b0} + 10'(d));
  endfunction

  acc_t acc, acc_next;
  logic v1, v2, v3, v4, v5;
  acc_t s1;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  s4_t  s4, s4_next;
  s5_t  s5, s5_next;

  logic               out_valid;
  logic signed [63:0] out_value;
  status_t            out_status;
  logic signed [63:0] out_value_next;

  logic        en;
  logic        is_digit;
  logic [3:0]  d;
  logic [63:0] nm;
  logic [4:0]  lim;
  logic [63:0] int_lim;
  logic [3:0]  mi;
  logic [27:0] p100;
  logic [24:0] p400;

  assign en    = !out_valid || result_out.ready;
  assign q_pop = en;

  // Character accumulation, one queue entry per cycle while the output is not stalled.
  always_comb begin
    acc_next = acc;
    is_digit = (q_op.ch >= CHAR_ZERO) && (q_op.ch <= CHAR_NINE);
    d        = is_digit ? 4'(q_op.ch - CHAR_ZERO) : 4'd0;
    nm       = {acc.mag[60:0], 3'b000} + {acc.mag[62:0], 1'b0} + 64'(d);
    lim      = (q_op.ftype == VT_DATE) ? DATE_LEN : TS_LEN;
    acc_next.ftype = q_op.ftype;
    acc_next.len   = q_op.len;
    acc_next.seen  = q_op.seen;
    if (q_op.has_char) begin
      case (q_op.ftype)
        VT_INT16, VT_INT32, VT_INT64: begin
          if (q_op.rep_bad) acc_next.malf = 1'b1;
          if (q_op.pos == 5'd0 && q_op.ch == CHAR_MINUS) begin
            acc_next.neg = 1'b1;
          end else if (is_digit) begin
            acc_next.dseen = 1'b1;
            if (acc.mag > INT64_MAG_DIV10 || nm > INT64_NEG_MAG) begin
              acc_next.malf = 1'b1;
            end else begin
              acc_next.mag = nm;
            end
          end else begin
            acc_next.malf = 1'b1;
          end
        end
        VT_BOOL: begin
          if (q_op.rep_bad || !(q_op.pos < 5'd4 && q_op.ch == true_char(q_op.pos))) begin
            acc_next.bm[0] = 1'b0;
          end
          if (q_op.rep_bad || !(q_op.pos < 5'd5 && q_op.ch == false_char(q_op.pos))) begin
            acc_next.bm[1] = 1'b0;
          end
        end
        VT_DATE, VT_TIMESTAMP: begin
          if (q_op.rep_bad) acc_next.malf = 1'b1;
          if (q_op.pos < lim && !is_sep(q_op.pos)) begin
            if (!is_digit) acc_next.malf = 1'b1;
            if (q_op.pos < 5'd4) begin
              acc_next.year = 14'({acc.year, 3'b000} + {acc.year, 1'b0} + 17'(d));
            end else if (q_op.pos < 5'd7) begin
              acc_next.month = acc2(acc.month, d);
            end else if (q_op.pos < 5'd10) begin
              acc_next.day = acc2(acc.day, d);
            end else if (q_op.pos < 5'd13) begin
              acc_next.hour = acc2(acc.hour, d);
            end else if (q_op.pos < 5'd16) begin
              acc_next.minute = acc2(acc.minute, d);
            end else begin
              acc_next.second = acc2(acc.second, d);
            end
          end
        end
        default: acc_next = acc_next;
      endcase
    end
  end

  // Classification of the finished field and start of the calendar maths.
  always_comb begin
    case (s1.ftype)
      VT_INT16: int_lim = INT16_MAX;
      VT_INT32: int_lim = INT32_MAX;
      default:  int_lim = INT64_MAX;
    endcase
    int_lim = int_lim + 64'(s1.neg);
    mi      = (s1.month > 7'd2) ? 4'(s1.month - 7'd3) : 4'(s1.month + 7'd9);

    s2_next.status  = ST_UNSUPPORTED;
    s2_next.val     = 64'd0;
    s2_next.date_go = 1'b0;
    s2_next.is_ts   = (s1.ftype == VT_TIMESTAMP);
    s2_next.yp      = 15'(s1.year) + YEAR_BIAS - 15'(s1.month <= 7'd2);
    s2_next.doyb    = month_start(mi);
    s2_next.day     = s1.day;
    s2_next.hour    = s1.hour;
    s2_next.minute  = s1.minute;
    s2_next.second  = s1.second;
    case (s1.ftype)
      VT_INT16, VT_INT32, VT_INT64: begin
        if (!s1.seen) begin
          s2_next.status = ST_EMPTY_INT;
        end else if (s1.malf || !s1.dseen || s1.mag > int_lim) begin
          s2_next.status = ST_BAD_INT;
        end else begin
          s2_next.status = ST_OK;
          s2_next.val    = s1.neg ? 64'd0 - s1.mag : s1.mag;
        end
      end
      VT_BOOL: begin
        if (s1.bm[0] && s1.len == 5'd4) begin
          s2_next.status = ST_OK;
          s2_next.val    = 64'd1;
        end else if (s1.bm[1] && s1.len == 5'd5) begin
          s2_next.status = ST_OK;
        end else begin
          s2_next.status = ST_NOT_BOOL;
        end
      end
      VT_DATE, VT_TIMESTAMP: begin
        if (s1.len != ((s1.ftype == VT_DATE) ? DATE_LEN : TS_LEN) || s1.malf ||
            s1.month < 7'd1 || s1.month > 7'd12) begin
          s2_next.status = ST_BAD_DATE;
        end else begin
          s2_next.status  = ST_OK;
          s2_next.date_go = 1'b1;
        end
      end
      default: s2_next.status = ST_UNSUPPORTED;
    endcase
  end

  // Leap corrections by reciprocal multiplication, exact for these ranges.
  always_comb begin
    p100 = 28'(s2.yp) * 28'(RECIP_100);
    p400 = 25'(s2.yp[14:2]) * 25'(RECIP_100);
    s3_next.status  = s2.status;
    s3_next.val     = s2.val;
    s3_next.date_go = s2.date_go;
    s3_next.is_ts   = s2.is_ts;
    s3_next.y365    = 24'(s2.yp) * 24'd365;
    s3_next.y4      = s2.yp[14:2];
    s3_next.q100    = 8'(p100 >> RECIP_SHIFT);
    s3_next.q400    = 6'(p400 >> RECIP_SHIFT);
    s3_next.doyb    = s2.doyb;
    s3_next.day     = s2.day;
    s3_next.hour    = s2.hour;
    s3_next.minute  = s2.minute;
    s3_next.second  = s2.second;
  end

  always_comb begin
    s4_next.status  = s3.status;
    s4_next.val     = s3.val;
    s4_next.date_go = s3.date_go;
    s4_next.is_ts   = s3.is_ts;
    s4_next.days    = 32'(s3.y365) + 32'(s3.y4) - 32'(s3.q100) + 32'(s3.q400) +
                      32'(s3.doyb) + 32'(s3.day) - 32'd1 - EPOCH_OFFSET;
    s4_next.hour    = s3.hour;
    s4_next.minute  = s3.minute;
    s4_next.second  = s3.second;
  end

  always_comb begin
    s5_next.status   = s4.status;
    s5_next.val      = s4.val;
    s5_next.date_go  = s4.date_go;
    s5_next.is_ts    = s4.is_ts;
    s5_next.days     = s4.days;
    s5_next.day_secs = $signed(s4.days) * 50'sd86400;
    s5_next.hms      = 19'(s4.hour) * 19'd3600 + 19'(s4.minute) * 19'd60 + 19'(s4.second);
  end

  always_comb begin
    if (!s5.date_go) begin
      out_value_next = $signed(s5.val);
    end else if (s5.is_ts) begin
      out_value_next = 64'(s5.day_secs) + 64'(s5.hms);
    end else begin
      out_value_next = 64'($signed(s5.days));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= ACC_CLEAR;
    end else if (en && q_valid) begin
      acc <= q_op.last ? ACC_CLEAR : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= q_valid && q_op.last;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1         <= acc_next;
      s2         <= s2_next;
      s3         <= s3_next;
      s4         <= s4_next;
      s5         <= s5_next;
      out_value  <= out_value_next;
      out_status <= s5.status;
    end
  end

  assign result_out.valid  = out_valid;
  assign result_out.value  = out_value;
  assign result_out.status = out_status;

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_value == 64'sd0)
    else $error("non-zero value with an error status");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    en && v5 |=> out_valid)
    else $error("finished field lost before the output register");

endmodule

[hdl/text_field_to_typed_value_parser.sv]
// ----------------------------------------------------------------------------
// text_field_to_typed_value_parser
// Parses a streamed text field into an integer, boolean, date or timestamp.
// ----------------------------------------------------------------------------
// Throughput: one character transfer per cycle while the queue is not full,
// fields back to back. A result passes through the queue, the accumulation
// register and five result stages (s2 to s5 and the output register); a
// stalled output holds them. The calendar maths sets the depth of that path.
// Reset (rst, synchronous) empties the queue and pipeline and closes any field.
module text_field_to_typed_value_parser
  import ttv_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  ttv_char_if.sink     field_in,
  ttv_result_if.source result_out
);

  logic push;
  op_t  push_op;
  logic q_full;
  logic q_valid;
  op_t  q_op;
  logic q_pop;

  ttv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .field_in (field_in),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  ttv_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_op    (q_op),
    .pop       (q_pop)
  );

  ttv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .result_out (result_out)
  );

endmodule

[tb/sv/tb_ttv_channels.sv]
// ----------------------------------------------------------------------------
// tb_ttv_channels
// Testbench-side types shared by the parser test: the transfer and the result.
// ----------------------------------------------------------------------------
package tb_ttv_helpers;
  import ttv_pkg::*;

  // One character transfer as the testbench offers it.
  typedef struct {
    logic [7:0]  char_code;
    logic        char_valid;
    logic        last;
    value_type_t vtype;
  } char_beat_t;

  // One expected result.
  typedef struct {
    logic signed [63:0] value;
    status_t            status;
  } parse_result_t;
endpackage

[tb/sv/tb_text_field_to_typed_value_parser.sv]
// ----------------------------------------------------------------------------
// tb_text_field_to_typed_value_parser
// Streams text fields into the parser and checks every typed result against
// a behavioural predictor, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_text_field_to_typed_value_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import ttv_pkg::*;
  import tb_ttv_helpers::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  bit quiet_phase = 1'b0;
  bit hold_sink = 1'b0;

  ttv_char_if   field_ch();
  ttv_result_if result_ch();

  text_field_to_typed_value_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .field_in   (field_ch.sink),
    .result_out (result_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state for the field in progress.
  value_type_t  pr_type;
  bit           pr_open;
  bit           pr_seen;
  int unsigned  pr_pos;
  int unsigned  pr_spaces;
  bit           pr_neg;
  bit [63:0]    pr_mag;
  bit           pr_digit;
  bit           pr_bad;
  bit [1:0]     pr_bool;
  bit [13:0]    pr_year;
  bit [6:0]     pr_month, pr_day, pr_hour, pr_minute, pr_second;

  parse_result_t expected_results[$];

  task automatic clear_field();
    pr_seen = 0; pr_pos = 0; pr_spaces = 0; pr_neg = 0; pr_mag = '0;
    pr_digit = 0; pr_bad = 0; pr_bool = 2'b11;
    pr_year = '0; pr_month = '0; pr_day = '0;
    pr_hour = '0; pr_minute = '0; pr_second = '0;
  endtask

  function automatic bit blank(input bit [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit [6:0] two_digit(input bit [6:0] acc, input int unsigned d);
    return 7'((acc * 10 + d) & 'h7F);
  endfunction

  task automatic take_char(input bit [7:0] c);
    string tword, fword;
    bit dig;
    int unsigned d;
    bit sep;
    int unsigned lim;
    bit [63:0] nm;
    tword = "true";
    fword = "false";
    dig = c >= "0" && c <= "9";
    d = dig ? c - "0" : 0;
    if (pr_type inside {VT_INT16, VT_INT32, VT_INT64}) begin
      if (pr_pos == 0 && c == "-") begin
        pr_neg = 1;
      end else if (dig) begin
        pr_digit = 1;
        if (pr_mag > 64'd922337203685477580) begin
          pr_bad = 1;
        end else begin
          nm = pr_mag * 10 + d;
          if (nm > 64'h8000_0000_0000_0000) pr_bad = 1;
          else pr_mag = nm;
        end
      end else begin
        pr_bad = 1;
      end
    end else if (pr_type == VT_BOOL) begin
      if (!(pr_pos < 4 && c == tword[pr_pos])) pr_bool[0] = 0;
      if (!(pr_pos < 5 && c == fword[pr_pos])) pr_bool[1] = 0;
    end else if (pr_type == VT_DATE || pr_type == VT_TIMESTAMP) begin
      lim = (pr_type == VT_DATE) ? 10 : 19;
      sep = pr_pos inside {4, 7, 10, 13, 16};
      if (pr_pos < lim && !sep) begin
        if (!dig) pr_bad = 1;
        if (pr_pos < 4) pr_year = 14'(pr_year * 10 + d);
        else if (pr_pos < 7) pr_month = two_digit(pr_month, d);
        else if (pr_pos < 10) pr_day = two_digit(pr_day, d);
        else if (pr_pos < 13) pr_hour = two_digit(pr_hour, d);
        else if (pr_pos < 16) pr_minute = two_digit(pr_minute, d);
        else pr_second = two_digit(pr_second, d);
      end
    end
    if (pr_pos < 31) pr_pos++;
  endtask

  function automatic longint days_since_epoch(input longint y, input longint m,
                                              input longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y -= 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic parse_result_t field_outcome();
    parse_result_t r;
    bit [63:0] plim;
    longint dd;
    r.value = '0;
    if (pr_type inside {VT_INT16, VT_INT32, VT_INT64}) begin
      plim = pr_type == VT_INT16 ? INT16_MAX : pr_type == VT_INT32 ? INT32_MAX : INT64_MAX;
      if (pr_neg) plim = plim + 1;
      if (!pr_seen) r.status = ST_EMPTY_INT;
      else if (pr_bad || !pr_digit || pr_mag > plim) r.status = ST_BAD_INT;
      else begin
        r.status = ST_OK;
        r.value = pr_neg ? -pr_mag : pr_mag;
      end
    end else if (pr_type == VT_BOOL) begin
      if (pr_bool[0] && pr_pos == 4) begin r.status = ST_OK; r.value = 1; end
      else if (pr_bool[1] && pr_pos == 5) r.status = ST_OK;
      else r.status = ST_NOT_BOOL;
    end else if (pr_type == VT_DATE || pr_type == VT_TIMESTAMP) begin
      if (pr_pos != (pr_type == VT_DATE ? 10 : 19) || pr_bad || pr_month < 1
          || pr_month > 12) begin
        r.status = ST_BAD_DATE;
      end else begin
        dd = days_since_epoch(pr_year, pr_month, pr_day);
        if (pr_type == VT_TIMESTAMP)
          dd = dd * 86400 + longint'(pr_hour) * 3600 + longint'(pr_minute) * 60
               + longint'(pr_second);
        r.status = ST_OK;
        r.value = dd;
      end
    end else begin
      r.status = ST_UNSUPPORTED;
    end
    return r;
  endfunction

  task automatic predict_beat(input char_beat_t b);
    if (!pr_open) begin
      pr_type = b.vtype;
      clear_field();
      pr_open = 1;
    end
    if (b.char_valid) begin
      if (blank(b.char_code)) begin
        if (pr_seen && pr_spaces < 31) pr_spaces++;
      end else begin
        while (pr_spaces > 0) begin
          take_char(8'd32);
          pr_spaces--;
        end
        pr_seen = 1;
        take_char(b.char_code);
      end
    end
    if (b.last) begin
      expected_results.push_back(field_outcome());
      pr_open = 0;
      clear_field();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Offers one transfer, idling at random first, and waits for acceptance.
  task automatic send_beat(input char_beat_t b);
    while (!quiet_phase && $urandom_range(99) < 31) begin
      field_ch.valid <= 1'b0;
      @(posedge clk);
    end
    field_ch.valid      <= 1'b1;
    field_ch.char_code  <= b.char_code;
    field_ch.char_valid <= b.char_valid;
    field_ch.last       <= b.last;
    field_ch.value_type <= b.vtype;
    do @(posedge clk); while (!field_ch.ready);
    predict_beat(b);
  endtask

  task automatic send_text(input value_type_t vt, input string s);
    char_beat_t b;
    if (s.len() == 0) begin
      b.char_code = 8'($urandom); b.char_valid = 0; b.last = 1; b.vtype = vt;
      send_beat(b);
    end
    for (int i = 0; i < s.len(); i++) begin
      b.char_code = s[i]; b.char_valid = 1; b.last = (i == s.len() - 1);
      b.vtype = vt;
      send_beat(b);
    end
  endtask

  task automatic drain();
    field_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic string digits(input int unsigned n);
    string s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string two(input int unsigned v);
    return $sformatf("%02d", v);
  endfunction

  function automatic string random_date();
    return $sformatf("%04d-%s-%s", $urandom_range(9999), two($urandom_range(13)),
                     two($urandom_range(99)));
  endfunction

  function automatic string pad(input string s);
    string h = "";
    string t = "";
    string ws = " \t\n\r";
    repeat ($urandom_range(2)) h = {h, string'(ws[$urandom_range(3)])};
    repeat ($urandom_range(2)) t = {t, string'(ws[$urandom_range(3)])};
    return {h, s, t};
  endfunction

  // Sink side: random stalls, or a long hold when asked.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !hold_sink && (quiet_phase || $urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    parse_result_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_results.pop_front();
        if (result_ch.value !== e.value)
          report_mismatch($sformatf("value %0d, expected %0d", result_ch.value, e.value));
        if (result_ch.status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", result_ch.status,
                                    e.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_integers();
    send_text(VT_INT16, "32767");
    send_text(VT_INT16, "-32768");
    send_text(VT_INT16, "32768");
    send_text(VT_INT32, "  -2147483648 \t");
    send_text(VT_INT64, "9223372036854775807");
    send_text(VT_INT64, "-9223372036854775808");
    send_text(VT_INT64, "99999999999999999999");
    send_text(VT_INT32, "");
    send_text(VT_INT32, "-");
    send_text(VT_INT32, "1 2");
    send_text(VT_INT16, "--5");
  endtask

  task automatic test_bool_and_other();
    send_text(VT_BOOL, " true ");
    send_text(VT_BOOL, "false");
    send_text(VT_BOOL, "True");
    send_text(VT_BOOL, "");
    send_text(VT_STRING, "hello");
    send_text(VT_INT128, "");
  endtask

  task automatic test_calendar();
    send_text(VT_DATE, "1970-01-01");
    send_text(VT_DATE, "0000-03-01");
    send_text(VT_DATE, "9999-12-31");
    send_text(VT_DATE, "2020-13-01");
    send_text(VT_DATE, "20a0-01-01");
    send_text(VT_TIMESTAMP, "2038-01-19T03:14:07");
    send_text(VT_TIMESTAMP, "1969-12-31 99:99:99");
    send_text(VT_DATE, "2000-02-2900000000000000000000000000000");
  endtask

  task automatic random_field();
    value_type_t vt;
    string s;
    char_beat_t b;
    int unsigned n;
    vt = value_type_t'($urandom_range(7));
    case ($urandom_range(9))
      0: s = digits($urandom_range(25));
      1: s = {"-", digits($urandom_range(20))};
      2: s = $urandom_range(1) ? "true" : "false";
      3, 4: s = random_date();
      5, 6: s = {random_date(), "T", two($urandom_range(99)), ":",
                 two($urandom_range(99)), ":", two($urandom_range(99))};
      default: begin
        s = "";
        n = $urandom_range(12);
        repeat (n) s = {s, string'(byte'($urandom_range(255)))};
      end
    endcase
    if (vt inside {VT_INT16, VT_INT32, VT_INT64} && $urandom_range(1)) s = digits(6);
    s = pad(s);
    // Some fields carry empty transfers before some of their characters.
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(15) == 0) begin
        b.char_code = 8'($urandom); b.char_valid = 0; b.last = 0; b.vtype = vt;
        send_beat(b);
      end
      b.char_code = s[i]; b.char_valid = 1; b.last = (i == s.len() - 1);
      b.vtype = value_type_t'($urandom_range(7));
      if (i == 0) b.vtype = vt;
      send_beat(b);
    end
    if (s.len() == 0) send_text(vt, "");
  endtask

  task automatic test_random(input int unsigned fields);
    repeat (fields) random_field();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    field_ch.valid      <= 1'b0;
    field_ch.char_code  <= '0;
    field_ch.char_valid <= 1'b0;
    field_ch.last       <= 1'b0;
    field_ch.value_type <= VT_INT16;
    pr_open = 0;
    clear_field();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_integers();
    test_bool_and_other();
    test_calendar();
    test_random(30);
    quiet_phase = 1'b1;
    test_random(20);
    quiet_phase = 1'b0;
    test_backpressure();
    test_random(25);
    drain();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
